>>> design/v2n_pkg.sv
// Package for the 2D vector normalizer: widths shared by the pipeline stages.
// No dependencies.
package v2n_pkg;
   localparam int CompW = 32;
   localparam int LenW = 32;
   localparam int UnitW = 18;
   localparam int FracBits = 16;
   localparam int SumW = 64;
   localparam int MagW = 32;
   localparam int DivW = MagW + FracBits;
   localparam int DivQW = 17;
endpackage

>>> design/v2n_sqrt_cell.sv
// One digit cell of the square root chain: one result bit per cycle while enabled.
// Depends on v2n_pkg.
module v2n_sqrt_cell import v2n_pkg::*; #(
   parameter int Step = 0
) (
   input  logic              clock,
   input  logic              en,
   input  logic [SumW-1:0]   rem_i,
   input  logic [LenW-1:0]   root_i,
   input  logic [MagW-1:0]   ax_i,
   input  logic [MagW-1:0]   ay_i,
   input  logic              sx_i,
   input  logic              sy_i,
   output logic [SumW-1:0]   rem_o,
   output logic [LenW-1:0]   root_o,
   output logic [MagW-1:0]   ax_o,
   output logic [MagW-1:0]   ay_o,
   output logic              sx_o,
   output logic              sy_o
);
   localparam int Sh = 2 * (LenW - 1 - Step);
   logic [SumW+1:0] trial;
   logic [SumW+1:0] rem_in_w;
   logic [SumW-1:0] rem_in;
   logic [LenW-1:0] root_in;
   logic [SumW-1:0] rem_ff;
   logic [LenW-1:0] root_ff;
   logic [MagW-1:0] ax_ff, ay_ff;
   logic sx_ff, sy_ff;

   always_comb begin
      trial = (SumW+2)'({root_i, 2'b01}) << Sh;
      rem_in_w = {2'b00, rem_i};
      rem_in = rem_i;
      root_in = {root_i[LenW-2:0], 1'b0};
      if (rem_in_w >= trial) begin
         rem_in = SumW'(rem_in_w - trial);
         root_in = {root_i[LenW-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         ax_ff <= ax_i;
         ay_ff <= ay_i;
         sx_ff <= sx_i;
         sy_ff <= sy_i;
      end
   end

   assign rem_o = rem_ff;
   assign root_o = root_ff;
   assign ax_o = ax_ff;
   assign ay_o = ay_ff;
   assign sx_o = sx_ff;
   assign sy_o = sy_ff;
endmodule

>>> design/v2n_div_cell.sv
// One quotient bit cell for both component divisions by the length.
// Depends on v2n_pkg.
module v2n_div_cell import v2n_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [LenW-1:0]   len_i,
   input  logic [DivW-1:0]   nx_i,
   input  logic [DivW-1:0]   ny_i,
   input  logic [LenW:0]     rx_i,
   input  logic [LenW:0]     ry_i,
   input  logic [DivQW-1:0]  qx_i,
   input  logic [DivQW-1:0]  qy_i,
   input  logic              sx_i,
   input  logic              sy_i,
   output logic [LenW-1:0]   len_o,
   output logic [DivW-1:0]   nx_o,
   output logic [DivW-1:0]   ny_o,
   output logic [LenW:0]     rx_o,
   output logic [LenW:0]     ry_o,
   output logic [DivQW-1:0]  qx_o,
   output logic [DivQW-1:0]  qy_o,
   output logic              sx_o,
   output logic              sy_o
);
   logic [LenW+1:0] tx, ty;
   logic [LenW:0] rx_in, ry_in;
   logic [DivQW-1:0] qx_in, qy_in;
   logic [LenW-1:0] len_ff;
   logic [DivW-1:0] nx_ff, ny_ff;
   logic [LenW:0] rx_ff, ry_ff;
   logic [DivQW-1:0] qx_ff, qy_ff;
   logic sx_ff, sy_ff;

   always_comb begin
      tx = {rx_i, nx_i[DivW-1]};
      ty = {ry_i, ny_i[DivW-1]};
      if (tx >= {2'b00, len_i}) begin
         rx_in = (LenW+1)'(tx - {2'b00, len_i});
         qx_in = {qx_i[DivQW-2:0], 1'b1};
      end else begin
         rx_in = (LenW+1)'(tx);
         qx_in = {qx_i[DivQW-2:0], 1'b0};
      end
      if (ty >= {2'b00, len_i}) begin
         ry_in = (LenW+1)'(ty - {2'b00, len_i});
         qy_in = {qy_i[DivQW-2:0], 1'b1};
      end else begin
         ry_in = (LenW+1)'(ty);
         qy_in = {qy_i[DivQW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff <= len_i;
         nx_ff <= {nx_i[DivW-2:0], 1'b0};
         ny_ff <= {ny_i[DivW-2:0], 1'b0};
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         sx_ff <= sx_i;
         sy_ff <= sy_i;
      end
   end

   assign len_o = len_ff;
   assign nx_o = nx_ff;
   assign ny_o = ny_ff;
   assign rx_o = rx_ff;
   assign ry_o = ry_ff;
   assign qx_o = qx_ff;
   assign qy_o = qy_ff;
   assign sx_o = sx_ff;
   assign sy_o = sy_ff;
endmodule

>>> design/vector2_normalize.sv
// Top level of the 2D vector normalizer: squares, square root chain, divide chain.
// Depends on v2n_pkg, v2n_sqrt_cell, v2n_div_cell.
//
//   port group   dir   payload
//   req_         in    x_in, y_in (signed Q16.16)
//   rsp_         out   length_out, unit_x, unit_y, zero_length
//
// One beat per cycle while the output is not stalled; 2 + 32 + 48 + 1 = 83 stages,
// set by the one bit per cell root and divide chains.
// Reset clears the valid bits of every stage and holds ready low; payload is not reset.
// A stalled output freezes the whole pipeline; ready is high whenever the
// output stage is empty or being taken and reset is low.
module vector2_normalize import v2n_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [CompW-1:0] req_x_in,
   input  logic signed [CompW-1:0] req_y_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [LenW-1:0]         rsp_length_out,
   output logic signed [UnitW-1:0] rsp_unit_x,
   output logic signed [UnitW-1:0] rsp_unit_y,
   output logic                    rsp_zero_length
);
   localparam int NS = LenW;
   localparam int ND = DivW;
   localparam int NV = 2 + NS + ND + 1;

   logic adv;
   logic [NV-1:0] vld_ff;
   logic [NV-1:0] vld_in;

   assign adv = !vld_ff[NV-1] || rsp_ready;
   assign req_ready = adv && !reset;
   assign rsp_valid = vld_ff[NV-1];

   always_comb begin
      vld_in = {vld_ff[NV-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   logic [MagW-1:0] ax_ff, ay_ff;
   logic sx_ff, sy_ff;
   logic [SumW-1:0] px_ff, py_ff;
   logic [MagW-1:0] ax2_ff, ay2_ff;
   logic sx2_ff, sy2_ff;
   logic [SumW-1:0] sum;

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff <= req_x_in[CompW-1];
         sy_ff <= req_y_in[CompW-1];
         ax_ff <= req_x_in[CompW-1] ? MagW'(-req_x_in) : MagW'(req_x_in);
         ay_ff <= req_y_in[CompW-1] ? MagW'(-req_y_in) : MagW'(req_y_in);
         px_ff <= SumW'(ax_ff) * SumW'(ax_ff);
         py_ff <= SumW'(ay_ff) * SumW'(ay_ff);
         ax2_ff <= ax_ff;
         ay2_ff <= ay_ff;
         sx2_ff <= sx_ff;
         sy2_ff <= sy_ff;
      end
   end
   assign sum = px_ff + py_ff;

   logic [SumW-1:0] s_rem [0:NS];
   logic [LenW-1:0] s_root [0:NS];
   logic [MagW-1:0] s_ax [0:NS];
   logic [MagW-1:0] s_ay [0:NS];
   logic s_sx [0:NS];
   logic s_sy [0:NS];

   assign s_rem[0] = sum;
   assign s_root[0] = '0;
   assign s_ax[0] = ax2_ff;
   assign s_ay[0] = ay2_ff;
   assign s_sx[0] = sx2_ff;
   assign s_sy[0] = sy2_ff;

   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      v2n_sqrt_cell #(.Step(i)) u_cell (
         .clock(clock), .en(adv),
         .rem_i(s_rem[i]), .root_i(s_root[i]), .ax_i(s_ax[i]), .ay_i(s_ay[i]),
         .sx_i(s_sx[i]), .sy_i(s_sy[i]),
         .rem_o(s_rem[i+1]), .root_o(s_root[i+1]), .ax_o(s_ax[i+1]),
         .ay_o(s_ay[i+1]), .sx_o(s_sx[i+1]), .sy_o(s_sy[i+1])
      );
   end

   logic [LenW-1:0] d_len [0:ND];
   logic [DivW-1:0] d_nx [0:ND];
   logic [DivW-1:0] d_ny [0:ND];
   logic [LenW:0] d_rx [0:ND];
   logic [LenW:0] d_ry [0:ND];
   logic [DivQW-1:0] d_qx [0:ND];
   logic [DivQW-1:0] d_qy [0:ND];
   logic d_sx [0:ND];
   logic d_sy [0:ND];

   assign d_len[0] = s_root[NS];
   assign d_nx[0] = {s_ax[NS], {FracBits{1'b0}}};
   assign d_ny[0] = {s_ay[NS], {FracBits{1'b0}}};
   assign d_rx[0] = '0;
   assign d_ry[0] = '0;
   assign d_qx[0] = '0;
   assign d_qy[0] = '0;
   assign d_sx[0] = s_sx[NS];
   assign d_sy[0] = s_sy[NS];

   for (genvar j = 0; j < ND; j++) begin : g_div
      v2n_div_cell u_cell (
         .clock(clock), .en(adv), .len_i(d_len[j]),
         .nx_i(d_nx[j]), .ny_i(d_ny[j]), .rx_i(d_rx[j]), .ry_i(d_ry[j]),
         .qx_i(d_qx[j]), .qy_i(d_qy[j]), .sx_i(d_sx[j]), .sy_i(d_sy[j]),
         .len_o(d_len[j+1]), .nx_o(d_nx[j+1]), .ny_o(d_ny[j+1]),
         .rx_o(d_rx[j+1]), .ry_o(d_ry[j+1]), .qx_o(d_qx[j+1]), .qy_o(d_qy[j+1]),
         .sx_o(d_sx[j+1]), .sy_o(d_sy[j+1])
      );
   end

   logic [LenW-1:0] len_ff;
   logic signed [UnitW-1:0] ux_ff, uy_ff;
   logic zero_ff;
   logic zero_in;
   logic [UnitW-1:0] mx, my;

   always_comb begin
      zero_in = (d_len[ND] == '0);
      mx = {1'b0, d_qx[ND]};
      my = {1'b0, d_qy[ND]};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff <= d_len[ND];
         zero_ff <= zero_in;
         ux_ff <= zero_in ? '0 : (d_sx[ND] ? -mx : mx);
         uy_ff <= zero_in ? '0 : (d_sy[ND] ? -my : my);
      end
   end

   assign rsp_length_out = len_ff;
   assign rsp_unit_x = ux_ff;
   assign rsp_unit_y = uy_ff;
   assign rsp_zero_length = zero_ff;
endmodule
